// ===== rtl/core/tfn_pkg.sv =====
// shared constants for the triangle face normal pipeline
`timescale 1ns / 1ps
`default_nettype none

package tfn_pkg;

    // coordinate width default (signed, 12 fraction bits)
    localparam int COORD_WIDTH_DEF = 16;

    // elevation offset and scale factor formats (signed q.14)
    localparam int ELEV_W  = 16;
    localparam int SCALE_W = ELEV_W + 1;
    localparam logic signed [SCALE_W-1:0] ONE_Q14 = SCALE_W'(16384);

    // normal component format (signed q2.14) and unit value
    localparam int NORM_W = 16;
    localparam logic signed [NORM_W-1:0] NORM_ONE = NORM_W'(16384);

    // chunked multiplier: chunk size and register stages
    localparam int MUL_CHUNK = 24;
    localparam int MUL_LAT   = 3;

    // front end: scale, edges, magnitudes, products, sign, cross, magnitude,
    // squares and sum
    localparam int CROSS_LAT = 7 + 2 * MUL_LAT;

    // ratio 2^30 * c^2 / s has 31 bits, its integer root 16 bits
    localparam int Q_BITS    = 31;
    localparam int ROOT_BITS = (Q_BITS + 1) / 2;

    // total register stages from input to output register
    localparam int PIPE_LAT = CROSS_LAT + Q_BITS + ROOT_BITS + 1;

endpackage

`default_nettype wire

// ===== rtl/core/tfn_umul.sv =====
// pipelined unsigned multiplier built from registered chunk products
`timescale 1ns / 1ps
`default_nettype none

module tfn_umul #(
    parameter int AW = 34,
    parameter int BW = 34
) (
    input  logic               clk,
    input  logic               en,
    input  logic [AW-1:0]      a,
    input  logic [BW-1:0]      b,
    output logic [AW+BW-1:0]   p
);
    import tfn_pkg::*;

    localparam int CH  = MUL_CHUNK;
    localparam int NA  = (AW + CH - 1) / CH;
    localparam int NB  = (BW + CH - 1) / CH;
    localparam int PAW = NA * CH;
    localparam int PBW = NB * CH;
    localparam int FW  = PAW + PBW;

    logic [PAW-1:0]    a_pad;
    logic [PBW-1:0]    b_pad;
    logic [2*CH-1:0]   pp_reg [NA][NB];
    logic [FW-1:0]     row_next [NA];
    logic [FW-1:0]     row_reg [NA];
    logic [AW+BW-1:0]  p_next;
    logic [AW+BW-1:0]  p_reg;

    assign a_pad = PAW'(a);
    assign b_pad = PBW'(b);

    // stage 1: chunk by chunk partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NA; i++)
            begin
                for (int j = 0; j < NB; j++)
                begin
                    pp_reg[i][j] <= a_pad[i*CH +: CH] * b_pad[j*CH +: CH];
                end
            end
        end
    end

    // stage 2: one row sum per chunk of a
    always_comb
    begin
        logic [FW-1:0] acc;
        for (int i = 0; i < NA; i++)
        begin
            acc = '0;
            for (int j = 0; j < NB; j++)
            begin
                acc = acc + (FW'(pp_reg[i][j]) << (j * CH));
            end
            row_next[i] = acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NA; i++)
            begin
                row_reg[i] <= row_next[i];
            end
        end
    end

    // stage 3: add the rows
    always_comb
    begin
        logic [FW-1:0] tot;
        tot = '0;
        for (int i = 0; i < NA; i++)
        begin
            tot = tot + (row_reg[i] << (i * CH));
        end
        p_next = tot[AW+BW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ===== rtl/core/tfn_cross.sv =====
// front end: vertex scaling, edges, exact cross product, squares and their sum
`timescale 1ns / 1ps
`default_nettype none

module tfn_cross #(
    parameter int CW = tfn_pkg::COORD_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [CW-1:0]              pos  [3][3],
    input  logic signed [tfn_pkg::ELEV_W-1:0] elev [3],
    output logic [4*(CW+18)-1:0]              sq   [3],
    output logic [4*(CW+18)+1:0]              sum,
    output logic [2:0]                        sign
);
    import tfn_pkg::*;

    localparam int VW   = CW + SCALE_W;
    localparam int EW   = VW + 1;
    localparam int PW   = 2 * EW;
    localparam int CXW  = PW + 1;
    localparam int MW   = PW;
    localparam int RW   = 2 * MW;
    localparam int SUMW = RW + 2;

    logic signed [SCALE_W-1:0] scale [3];
    logic signed [VW-1:0]      v_reg [3][3];
    logic signed [EW-1:0]      e1_reg [3];
    logic signed [EW-1:0]      e2_reg [3];
    logic [EW-1:0]             ma_reg [6];
    logic [EW-1:0]             mb_reg [6];
    logic [5:0]                psgn_reg;
    logic [5:0]                psgn_dly_reg [MUL_LAT];
    logic [PW-1:0]             prod [6];
    logic signed [CXW-1:0]     sp_reg [6];
    logic signed [CXW-1:0]     c_reg [3];
    logic [MW-1:0]             cmag_reg [3];
    logic [3:0]                cflag_reg;
    logic [3:0]                cflag_dly_reg [MUL_LAT];
    logic [RW-1:0]             csq [3];
    logic [RW-1:0]             sq_reg [3];
    logic [SUMW-1:0]           sum_reg;
    logic [2:0]                sign_reg;

    // scale factor 1 + elevation
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            scale[i] = SCALE_W'(elev[i]) + ONE_Q14;
        end
    end

    // scaled vertices
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    v_reg[i][j] <= VW'(pos[i][j]) * VW'(scale[i]);
                end
            end
        end
    end

    // edges from the first vertex
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                e1_reg[j] <= EW'(v_reg[1][j]) - EW'(v_reg[0][j]);
                e2_reg[j] <= EW'(v_reg[2][j]) - EW'(v_reg[0][j]);
            end
        end
    end

    // operand magnitudes and product signs, first terms then second terms
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                ma_reg[j]     <= e1_reg[(j+1)%3][EW-1] ? EW'(-e1_reg[(j+1)%3])
                                                       : EW'(e1_reg[(j+1)%3]);
                mb_reg[j]     <= e2_reg[(j+2)%3][EW-1] ? EW'(-e2_reg[(j+2)%3])
                                                       : EW'(e2_reg[(j+2)%3]);
                psgn_reg[j]   <= e1_reg[(j+1)%3][EW-1] ^ e2_reg[(j+2)%3][EW-1];
                ma_reg[j+3]   <= e1_reg[(j+2)%3][EW-1] ? EW'(-e1_reg[(j+2)%3])
                                                       : EW'(e1_reg[(j+2)%3]);
                mb_reg[j+3]   <= e2_reg[(j+1)%3][EW-1] ? EW'(-e2_reg[(j+1)%3])
                                                       : EW'(e2_reg[(j+1)%3]);
                psgn_reg[j+3] <= e1_reg[(j+2)%3][EW-1] ^ e2_reg[(j+1)%3][EW-1];
            end
        end
    end

    // edge products, one multiplier for each first and second term
    for (genvar k = 0; k < 6; k++)
    begin : g_prod
        tfn_umul #(
            .AW (EW),
            .BW (EW)
        ) u_mul (
            .clk (clk),
            .en  (en),
            .a   (ma_reg[k]),
            .b   (mb_reg[k]),
            .p   (prod[k])
        );
    end

    // product signs follow the multiplier
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            psgn_dly_reg[0] <= psgn_reg;
            for (int d = 1; d < MUL_LAT; d++)
            begin
                psgn_dly_reg[d] <= psgn_dly_reg[d-1];
            end
        end
    end

    // signed products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 6; k++)
            begin
                sp_reg[k] <= psgn_dly_reg[MUL_LAT-1][k] ? -$signed({1'b0, prod[k]})
                                                        : $signed({1'b0, prod[k]});
            end
        end
    end

    // cross product components
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                c_reg[j] <= sp_reg[j] - sp_reg[j+3];
            end
        end
    end

    // component magnitudes, signs and the zero vector flag
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                cmag_reg[j]  <= c_reg[j][CXW-1] ? MW'(-c_reg[j]) : MW'(c_reg[j]);
                cflag_reg[j] <= c_reg[j][CXW-1];
            end
            cflag_reg[3] <= (c_reg[0] == '0) && (c_reg[1] == '0) && (c_reg[2] == '0);
        end
    end

    // squared magnitudes
    for (genvar j = 0; j < 3; j++)
    begin : g_sq
        tfn_umul #(
            .AW (MW),
            .BW (MW)
        ) u_sq (
            .clk (clk),
            .en  (en),
            .a   (cmag_reg[j]),
            .b   (cmag_reg[j]),
            .p   (csq[j])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cflag_dly_reg[0] <= cflag_reg;
            for (int d = 1; d < MUL_LAT; d++)
            begin
                cflag_dly_reg[d] <= cflag_dly_reg[d-1];
            end
        end
    end

    // squared length; a zero vector gets length one so every ratio is zero
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                sq_reg[j] <= csq[j];
            end
            sum_reg  <= cflag_dly_reg[MUL_LAT-1][3]
                        ? SUMW'(1)
                        : SUMW'(csq[0]) + SUMW'(csq[1]) + SUMW'(csq[2]);
            sign_reg <= cflag_dly_reg[MUL_LAT-1][2:0];
        end
    end

    assign sq   = sq_reg;
    assign sum  = sum_reg;
    assign sign = sign_reg;

endmodule

`default_nettype wire

// ===== rtl/core/tfn_div.sv =====
// restoring divider, one quotient bit per stage: floor(2^30 * num / den)
`timescale 1ns / 1ps
`default_nettype none

module tfn_div #(
    parameter int RW = 136
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [RW-1:0]               num,
    input  logic [RW+1:0]               den,
    input  logic                        sign_in,
    output logic [tfn_pkg::Q_BITS-1:0]  quo,
    output logic                        sign_out
);
    import tfn_pkg::*;

    localparam int DW = RW + 2;
    localparam int TW = DW + 1;

    logic [DW-1:0]      rem_reg [Q_BITS];
    logic [DW-1:0]      den_reg [Q_BITS];
    logic [Q_BITS-1:0]  quo_reg [Q_BITS];
    logic [Q_BITS-1:0]  sgn_reg;
    logic [TW-1:0]      trial [Q_BITS];
    logic [DW-1:0]      dsel  [Q_BITS];
    logic [Q_BITS-1:0]  qsel  [Q_BITS];
    logic [Q_BITS-1:0]  ssel;
    logic [Q_BITS-1:0]  take;

    // stage inputs: the first stage starts from num, which never exceeds den
    always_comb
    begin
        trial[0] = TW'(num);
        dsel[0]  = den;
        qsel[0]  = '0;
        ssel[0]  = sign_in;
        for (int k = 1; k < Q_BITS; k++)
        begin
            trial[k] = {rem_reg[k-1], 1'b0};
            dsel[k]  = den_reg[k-1];
            qsel[k]  = quo_reg[k-1];
            ssel[k]  = sgn_reg[k-1];
        end
        for (int k = 0; k < Q_BITS; k++)
        begin
            take[k] = trial[k] >= TW'(dsel[k]);
        end
    end

    // trial subtract per stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < Q_BITS; k++)
            begin
                rem_reg[k] <= take[k] ? DW'(trial[k] - TW'(dsel[k])) : DW'(trial[k]);
                den_reg[k] <= dsel[k];
                quo_reg[k] <= {qsel[k][Q_BITS-2:0], take[k]};
                sgn_reg[k] <= ssel[k];
            end
        end
    end

    assign quo      = quo_reg[Q_BITS-1];
    assign sign_out = sgn_reg[Q_BITS-1];

endmodule

`default_nettype wire

// ===== rtl/core/tfn_isqrt.sv =====
// integer square root, one result bit per stage
`timescale 1ns / 1ps
`default_nettype none

module tfn_isqrt (
    input  logic                           clk,
    input  logic                           en,
    input  logic [tfn_pkg::Q_BITS-1:0]     rad,
    input  logic                           sign_in,
    output logic [tfn_pkg::ROOT_BITS-1:0]  root,
    output logic                           sign_out
);
    import tfn_pkg::*;

    localparam int XW = 2 * ROOT_BITS;

    logic [XW-1:0]         x_reg [ROOT_BITS];
    logic [XW-1:0]         r_reg [ROOT_BITS];
    logic [ROOT_BITS-1:0]  sgn_reg;
    logic [XW-1:0]         x_in [ROOT_BITS];
    logic [XW-1:0]         r_in [ROOT_BITS];
    logic [ROOT_BITS-1:0]  s_in;
    logic [XW-1:0]         bitk [ROOT_BITS];
    logic [XW:0]           t    [ROOT_BITS];
    logic [ROOT_BITS-1:0]  take;

    // stage inputs and trial values
    always_comb
    begin
        x_in[0] = XW'(rad);
        r_in[0] = '0;
        s_in[0] = sign_in;
        for (int k = 1; k < ROOT_BITS; k++)
        begin
            x_in[k] = x_reg[k-1];
            r_in[k] = r_reg[k-1];
            s_in[k] = sgn_reg[k-1];
        end
        for (int k = 0; k < ROOT_BITS; k++)
        begin
            bitk[k] = XW'(1) << (2 * (ROOT_BITS - 1 - k));
            t[k]    = (XW+1)'(r_in[k]) + (XW+1)'(bitk[k]);
            take[k] = {1'b0, x_in[k]} >= t[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < ROOT_BITS; k++)
            begin
                x_reg[k]   <= take[k] ? XW'({1'b0, x_in[k]} - t[k]) : x_in[k];
                r_reg[k]   <= take[k] ? (r_in[k] >> 1) + bitk[k] : (r_in[k] >> 1);
                sgn_reg[k] <= s_in[k];
            end
        end
    end

    assign root     = r_reg[ROOT_BITS-1][ROOT_BITS-1:0];
    assign sign_out = sgn_reg[ROOT_BITS-1];

endmodule

`default_nettype wire

// ===== rtl/core/triangle_face_normal.sv =====
// top level: unit face normal of one triangle per transaction
// stages from input transaction to output valid: 13 front end, 31 divider,
//   16 square root, 1 output register
// throughput: one transaction per cycle; a stalled output holds the whole pipeline
// reset: rst_n clears the valid bit of every stage; data registers are not reset
`timescale 1ns / 1ps
`default_nettype none

module triangle_face_normal #(
    parameter int COORD_WIDTH = tfn_pkg::COORD_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [COORD_WIDTH-1:0]       a_x,
    input  logic signed [COORD_WIDTH-1:0]       a_y,
    input  logic signed [COORD_WIDTH-1:0]       a_z,
    input  logic signed [COORD_WIDTH-1:0]       b_x,
    input  logic signed [COORD_WIDTH-1:0]       b_y,
    input  logic signed [COORD_WIDTH-1:0]       b_z,
    input  logic signed [COORD_WIDTH-1:0]       c_x,
    input  logic signed [COORD_WIDTH-1:0]       c_y,
    input  logic signed [COORD_WIDTH-1:0]       c_z,
    input  logic signed [tfn_pkg::ELEV_W-1:0]   a_elev,
    input  logic signed [tfn_pkg::ELEV_W-1:0]   b_elev,
    input  logic signed [tfn_pkg::ELEV_W-1:0]   c_elev,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [tfn_pkg::NORM_W-1:0]   norm_x,
    output logic signed [tfn_pkg::NORM_W-1:0]   norm_y,
    output logic signed [tfn_pkg::NORM_W-1:0]   norm_z,
    output logic                                degenerate
);
    import tfn_pkg::*;

    localparam int EW = COORD_WIDTH + SCALE_W + 1;
    localparam int RW = 4 * EW;

    logic                       en;
    logic [PIPE_LAT-1:0]        vld_reg;
    logic signed [COORD_WIDTH-1:0] pos  [3][3];
    logic signed [ELEV_W-1:0]   elev [3];
    logic [RW-1:0]              sq   [3];
    logic [RW+1:0]              sum;
    logic [2:0]                 sign;
    logic [Q_BITS-1:0]          quo  [3];
    logic [2:0]                 qsign;
    logic [ROOT_BITS-1:0]       root [3];
    logic [2:0]                 rsign;
    logic [NORM_W-1:0]          q    [3];
    logic [ROOT_BITS:0]         rsum [3];
    logic signed [NORM_W-1:0]   norm_reg [3];
    logic                       degen_reg;

    // global advance: move when the output register is free or being taken
    assign en       = !vld_reg[PIPE_LAT-1] || out_ready;
    assign in_ready = en;

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], in_valid};
        end
    end

    assign pos[0][0] = a_x;
    assign pos[0][1] = a_y;
    assign pos[0][2] = a_z;
    assign pos[1][0] = b_x;
    assign pos[1][1] = b_y;
    assign pos[1][2] = b_z;
    assign pos[2][0] = c_x;
    assign pos[2][1] = c_y;
    assign pos[2][2] = c_z;
    assign elev[0]   = a_elev;
    assign elev[1]   = b_elev;
    assign elev[2]   = c_elev;

    // exact cross product and squared length
    tfn_cross #(
        .CW (COORD_WIDTH)
    ) u_cross (
        .clk  (clk),
        .en   (en),
        .pos  (pos),
        .elev (elev),
        .sq   (sq),
        .sum  (sum),
        .sign (sign)
    );

    // per component: floor(2^30 c^2 / s), then its integer root
    for (genvar j = 0; j < 3; j++)
    begin : g_comp
        tfn_div #(
            .RW (RW)
        ) u_div (
            .clk      (clk),
            .en       (en),
            .num      (sq[j]),
            .den      (sum),
            .sign_in  (sign[j]),
            .quo      (quo[j]),
            .sign_out (qsign[j])
        );

        tfn_isqrt u_sqrt (
            .clk      (clk),
            .en       (en),
            .rad      (quo[j]),
            .sign_in  (qsign[j]),
            .root     (root[j]),
            .sign_out (rsign[j])
        );
    end

    // round to nearest: largest q with (2q - 1) no greater than the root
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            rsum[j] = (ROOT_BITS+1)'(root[j]) + (ROOT_BITS+1)'(1);
            q[j]    = NORM_W'(rsum[j][ROOT_BITS:1]);
        end
    end

    // output register; only a zero vector leaves every component zero
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                norm_reg[j] <= rsign[j] ? -$signed(q[j]) : $signed(q[j]);
            end
            degen_reg <= (q[0] == '0) && (q[1] == '0) && (q[2] == '0);
        end
    end

    assign out_valid  = vld_reg[PIPE_LAT-1];
    assign norm_x     = norm_reg[0];
    assign norm_y     = norm_reg[1];
    assign norm_z     = norm_reg[2];
    assign degenerate = degen_reg;

endmodule

`default_nettype wire

// ===== rtl/core/tfn_checker.sv =====
// port level checks for the face normal pipeline, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module tfn_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_ready,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic signed [tfn_pkg::NORM_W-1:0]   norm_x,
    input  logic signed [tfn_pkg::NORM_W-1:0]   norm_y,
    input  logic signed [tfn_pkg::NORM_W-1:0]   norm_z,
    input  logic                                degenerate
);
    import tfn_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(norm_x) && $stable(norm_y)
                                    && $stable(norm_z) && $stable(degenerate))
        else $error("output transaction changed while stalled");

    // an empty output register never blocks the input
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output register");

    // a stalled output freezes the pipeline
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while pipeline frozen");

    // a degenerate face has a zero normal
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> norm_x == '0 && norm_y == '0 && norm_z == '0)
        else $error("degenerate face with nonzero normal");

    // components stay within unit range and a proper face has a nonzero normal
    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> norm_x <= NORM_ONE && norm_x >= -NORM_ONE
                   && norm_y <= NORM_ONE && norm_y >= -NORM_ONE
                   && norm_z <= NORM_ONE && norm_z >= -NORM_ONE
                   && (degenerate || norm_x != '0 || norm_y != '0 || norm_z != '0))
        else $error("normal component out of range");

endmodule

bind triangle_face_normal tfn_checker u_tfn_checker (.*);

`default_nettype wire

// ===== dv/triangle_face_normal_test.sv =====
// self-checking testbench for the triangle face normal pipeline
`timescale 1ns / 1ps

module triangle_face_normal_test;
    import tfn_pkg::*;

    typedef struct {
        logic signed [COORD_WIDTH_DEF-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
        logic signed [ELEV_W-1:0]          ae, be, ce;
    } face_t;

    typedef struct {
        logic signed [NORM_W-1:0] nx, ny, nz;
        logic                     degen;
    } normal_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [COORD_WIDTH_DEF-1:0] a_x = '0, a_y = '0, a_z = '0;
    logic signed [COORD_WIDTH_DEF-1:0] b_x = '0, b_y = '0, b_z = '0;
    logic signed [COORD_WIDTH_DEF-1:0] c_x = '0, c_y = '0, c_z = '0;
    logic signed [ELEV_W-1:0] a_elev = '0, b_elev = '0, c_elev = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [NORM_W-1:0] norm_x, norm_y, norm_z;
    logic degenerate;

    normal_t pending_normals[$];
    int      mismatches = 0;
    bit      steady_flow = 1'b0;   // no random idling on either side
    int      sink_hold = 0;        // cycles the receiver still refuses results

    triangle_face_normal dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .a_x(a_x), .a_y(a_y), .a_z(a_z),
        .b_x(b_x), .b_y(b_y), .b_z(b_z),
        .c_x(c_x), .c_y(c_y), .c_z(c_z),
        .a_elev(a_elev), .b_elev(b_elev), .c_elev(c_elev),
        .out_valid(out_valid), .out_ready(out_ready),
        .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
        .degenerate(degenerate)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // exact unit normal, rounded to nearest with ties away from zero
    function automatic normal_t face_normal(face_t f);
        logic signed [191:0] pos[3][3];
        logic signed [191:0] scale[3];
        logic signed [191:0] vtx[3][3];
        logic signed [191:0] e1[3], e2[3], cp[3];
        logic signed [191:0] sum_sq, target, kk;
        logic [191:0]        lhs;
        int                  lo, hi, mid, sgn_mag[3];
        normal_t             r;
        pos[0][0] = f.ax; pos[0][1] = f.ay; pos[0][2] = f.az;
        pos[1][0] = f.bx; pos[1][1] = f.by; pos[1][2] = f.bz;
        pos[2][0] = f.cx; pos[2][1] = f.cy; pos[2][2] = f.cz;
        scale[0] = 192'sd16384 + f.ae;
        scale[1] = 192'sd16384 + f.be;
        scale[2] = 192'sd16384 + f.ce;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                vtx[i][j] = pos[i][j] * scale[i];
        for (int j = 0; j < 3; j++)
        begin
            e1[j] = vtx[1][j] - vtx[0][j];
            e2[j] = vtx[2][j] - vtx[0][j];
        end
        for (int j = 0; j < 3; j++)
            cp[j] = e1[(j+1)%3] * e2[(j+2)%3] - e1[(j+2)%3] * e2[(j+1)%3];
        if (cp[0] == 0 && cp[1] == 0 && cp[2] == 0)
        begin
            r.nx = '0; r.ny = '0; r.nz = '0; r.degen = 1'b1;
            return r;
        end
        sum_sq = cp[0] * cp[0] + cp[1] * cp[1] + cp[2] * cp[2];
        for (int j = 0; j < 3; j++)
        begin
            target = (cp[j] * cp[j]) <<< 30;
            lo = 0;
            hi = 16384;
            // largest q with (2q-1)^2 * S <= 2^30 * c^2
            while (lo < hi)
            begin
                mid = (lo + hi + 1) / 2;
                kk = 2 * mid - 1;
                lhs = kk * kk * sum_sq;
                if (lhs <= $unsigned(target))
                    lo = mid;
                else
                    hi = mid - 1;
            end
            sgn_mag[j] = (cp[j] < 0) ? -lo : lo;
        end
        r.nx = sgn_mag[0][15:0];
        r.ny = sgn_mag[1][15:0];
        r.nz = sgn_mag[2][15:0];
        r.degen = 1'b0;
        return r;
    endfunction

    // offer one face and wait for its transaction, then maybe idle
    task automatic send_face(face_t f);
        int gap;
        in_valid <= 1'b1;
        a_x <= f.ax; a_y <= f.ay; a_z <= f.az;
        b_x <= f.bx; b_y <= f.by; b_z <= f.bz;
        c_x <= f.cx; c_y <= f.cy; c_z <= f.cz;
        a_elev <= f.ae; b_elev <= f.be; c_elev <= f.ce;
        do
            @(posedge clk);
        while (!in_ready);
        pending_normals.push_back(face_normal(f));
        if (!steady_flow && $urandom_range(99) < 25)
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic face_t rand_face(int coord_max, int elev_mode);
        face_t f;
        logic signed [15:0] w[9];
        logic signed [15:0] el[3];
        for (int i = 0; i < 9; i++)
        begin
            if (coord_max == 0)
                w[i] = $urandom;
            else
                w[i] = $urandom_range(2 * coord_max) - coord_max;
        end
        for (int i = 0; i < 3; i++)
            case (elev_mode)
                0: el[i] = $urandom;
                1: el[i] = 0;
                default: el[i] = $urandom_range(4000) - 2000;
            endcase
        f.ax = w[0]; f.ay = w[1]; f.az = w[2];
        f.bx = w[3]; f.by = w[4]; f.bz = w[5];
        f.cx = w[6]; f.cy = w[7]; f.cz = w[8];
        f.ae = el[0]; f.be = el[1]; f.ce = el[2];
        return f;
    endfunction

    // collinear vertices with no elevation: always degenerate
    function automatic face_t collinear_face();
        face_t f;
        int k;
        f = rand_face(1000, 1);
        k = $urandom_range(3) - 1;
        f.cx = f.ax + k * (f.bx - f.ax);
        f.cy = f.ay + k * (f.by - f.ay);
        f.cz = f.az + k * (f.bz - f.az);
        return f;
    endfunction

    // receiver: random stalls, forced hold-off, quiet stretch
    always @(posedge clk)
    begin
        if (sink_hold > 0)
        begin
            out_ready <= 1'b0;
            sink_hold = sink_hold - 1;
        end
        else
            out_ready <= steady_flow || ($urandom_range(99) >= 25);
    end

    // result checker
    always @(posedge clk)
    begin
        normal_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_normals.size() == 0)
            begin
                $error("result transaction with nothing expected");
                mismatches++;
            end
            else
            begin
                e = pending_normals.pop_front();
                if (norm_x !== e.nx)
                begin
                    $error("norm_x expected %0d actual %0d", e.nx, norm_x);
                    mismatches++;
                end
                if (norm_y !== e.ny)
                begin
                    $error("norm_y expected %0d actual %0d", e.ny, norm_y);
                    mismatches++;
                end
                if (norm_z !== e.nz)
                begin
                    $error("norm_z expected %0d actual %0d", e.nz, norm_z);
                    mismatches++;
                end
                if (degenerate !== e.degen)
                begin
                    $error("degenerate expected %0d actual %0d", e.degen, degenerate);
                    mismatches++;
                end
            end
        end
    end

    function automatic face_t make_face(int ax, int ay, int az, int bx, int by, int bz,
                                        int cx, int cy, int cz, int ae, int be, int ce);
        face_t f;
        f.ax = ax; f.ay = ay; f.az = az;
        f.bx = bx; f.by = by; f.bz = bz;
        f.cx = cx; f.cy = cy; f.cz = cz;
        f.ae = ae; f.be = be; f.ce = ce;
        return f;
    endfunction

    // directed corners: axes, zero area, extremes, non-positive scale
    task automatic test_directed();
        send_face(make_face(0, 0, 0, 4096, 0, 0, 0, 4096, 0, 0, 0, 0));
        send_face(make_face(0, 0, 0, 0, 4096, 0, 0, 0, 4096, 0, 0, 0));
        send_face(make_face(0, 0, 0, 0, 0, 4096, 4096, 0, 0, 0, 0, 0));
        send_face(make_face(0, 0, 0, 0, 4096, 0, 4096, 0, 0, 0, 0, 0));
        send_face(make_face(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_face(make_face(100, 200, 300, 100, 200, 300, 5, 6, 7, 0, 0, 0));
        send_face(make_face(0, 0, 0, 1000, 1000, 1000, 2000, 2000, 2000, 0, 0, 0));
        send_face(make_face(32767, 32767, 32767, -32768, -32768, -32768,
                            32767, -32768, 32767, 32767, 32767, 32767));
        send_face(make_face(-32768, 32767, -32768, 32767, -32768, 32767,
                            -32768, -32768, 32767, -32768, -32768, -32768));
        send_face(make_face(32767, 0, 0, 0, 32767, 0, 0, 0, 32767,
                            -32768, 32767, -32768));
        // zero scale on every vertex collapses the triangle
        send_face(make_face(100, 2, 3, 4, 500, 6, 7, 8, 900, -16384, -16384, -16384));
        // negative scale on one vertex
        send_face(make_face(0, 0, 0, 4096, 0, 0, 0, 4096, 0, 0, -20000, 0));
        send_face(make_face(1, 0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0));
        send_face(make_face(1, 2, 0, 3, 1, 0, 0, 0, 1, 0, 0, 0));
        send_face(make_face(-1, -1, -1, 1, 1, 1, 1, -1, 0, 16383, -1, 1));
        send_face(make_face(0, 0, 0, 3, 0, 0, 0, 4, 7, 0, 0, 0));
        send_face(make_face(-32768, -32768, -32768, -32768, -32768, 32767,
                            32767, -32768, -32768, 0, 0, 0));
    endtask

    // random faces of mixed size, with a quiet stretch in the middle
    task automatic test_random(int count);
        int sel;
        for (int n = 0; n < count; n++)
        begin
            steady_flow = (n >= count / 3 && n < count / 3 + 200);
            sel = $urandom_range(99);
            if (sel < 40)
                send_face(rand_face(0, 0));
            else if (sel < 60)
                send_face(rand_face(0, 2));
            else if (sel < 80)
                send_face(rand_face(20, $urandom_range(2)));
            else if (sel < 92)
                send_face(rand_face(3, 1));
            else
                send_face(collinear_face());
        end
        steady_flow = 1'b0;
    endtask

    // receiver refuses for a long time while faces keep coming
    task automatic test_backpressure();
        sink_hold = 300;
        for (int n = 0; n < 120; n++)
            send_face(rand_face(0, 0));
    endtask

    // sender waits until the pipeline has drained, then sends more faces
    task automatic test_drain_pause();
        in_valid <= 1'b0;
        while (pending_normals.size() != 0)
            @(posedge clk);
        for (int n = 0; n < 20; n++)
            send_face(rand_face(0, 2));
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(700);
        test_backpressure();
        test_drain_pause();
        test_random(760);
        in_valid <= 1'b0;
        while (pending_normals.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 10) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // watchdog
    initial
    begin
        #2ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
